// ===== hw/rtl/psgce_pkg.sv =====
// psgce_pkg: action codes, chip command bytes and controller state type
// for the sound-chip command encoder; no dependencies
package psgce_pkg;

  // action codes of an input transaction
  localparam logic [2:0] ACT_TONE    = 3'd0;
  localparam logic [2:0] ACT_VOLUME  = 3'd1;
  localparam logic [2:0] ACT_NOISE   = 3'd2;
  localparam logic [2:0] ACT_RESTART = 3'd3;
  localparam logic [2:0] ACT_MUTE    = 3'd4;
  localparam logic [2:0] ACT_PERIOD  = 3'd5;

  // chip command bytes
  localparam logic [7:0] BYTE_TONE   = 8'h80;
  localparam logic [7:0] BYTE_VOLUME = 8'h90;
  localparam logic [7:0] BYTE_MUTE   = 8'h9f;
  localparam logic [7:0] BYTE_NOISE  = 8'he0;
  localparam logic [7:0] BYTE_WHITE  = 8'h04;

  localparam logic [1:0] NOISE_VOICE = 2'd3;
  localparam logic [3:0] ATT_MAX     = 4'hf;
  localparam logic [15:0] TONE_MAX   = 16'd1023;
  localparam logic [15:0] RATE_MAX   = 16'd3;

  // clock-ratio register
  localparam int unsigned  RATIO_W     = 18;
  localparam logic [17:0]  RATIO_RESET = 18'd111861;

  // period-for-hz divider: 19-bit dividend, one quotient bit per cycle
  localparam int unsigned  NUM_W     = 19;
  localparam logic [4:0]   DIV_LAST  = 5'd18;
  localparam logic [18:0]  QUOT_MAX  = 19'd1023;

  // mute burst: sixteen bytes
  localparam logic [3:0]   MUTE_LAST = 4'd15;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

endpackage

// ===== hw/rtl/psg_command_encoder.sv =====
// psg_command_encoder: turns sound commands into chip write bytes for four
// four-voice tone/noise chips; depends on psgce_pkg
//
// One command is taken at a time. in_ready is high while the controller is
// idle, even if the previous result still sits in the output register.
// After the accept, tone emits two bytes, volume / noise / restart and
// rejected commands one result each, mute-all sixteen bytes (one byte per cycle
// while out_ready is high). Period-for-hz runs a restoring divider that
// produces one quotient bit per cycle over a 19-bit dividend, then emits
// one result; that divider loop sets the worst-case rate.
// Output stalls hold the emit state. clock_ratio sits at byte address 0
// of the apb-style port and should only be written while no command is in
// flight. Each chip keeps a noise-control shadow byte (reset 0xe0) that a
// restart-noise command resends.
module psg_command_encoder #(
  parameter int unsigned CHANNELS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_action,
  input  logic [7:0]  in_channel,
  input  logic [15:0] in_amount,
  input  logic        in_white_noise,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_chip_port,
  output logic [7:0]  out_out_byte,
  output logic        out_write_valid,
  output logic        out_status,
  output logic [9:0]  out_period_value,
  output logic        out_last,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import psgce_pkg::*;

  // ---------------------------------------------------------------------
  // configuration register
  // ---------------------------------------------------------------------
  logic [RATIO_W-1:0] ratio_r;
  logic               cfg_sel;

  // register 0 lives at byte address 0; address 4 and up is unmapped
  assign cfg_sel = (paddr[2] == 1'b0);
  assign pready  = 1'b1;
  assign prdata  = cfg_sel ? {{(32-RATIO_W){1'b0}}, ratio_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r <= RATIO_RESET;
    end else if (psel && penable && pwrite && pready && cfg_sel) begin
      ratio_r <= pwdata[RATIO_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // command decode and checks
  // ---------------------------------------------------------------------
  state_t      state_r;
  logic        accept;
  logic [1:0]  in_voice;
  logic [1:0]  in_chip;
  logic        chan_ok;
  logic        in_err;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign in_voice = in_channel[1:0];
  assign in_chip  = in_channel[3:2];
  assign chan_ok  = (in_channel < 8'(CHANNELS));

  always_comb begin
    case (in_action)
      ACT_TONE:    in_err = !chan_ok || (in_voice == NOISE_VOICE) ||
                            (in_amount == 16'd0) || (in_amount > TONE_MAX);
      ACT_VOLUME:  in_err = !chan_ok;
      ACT_NOISE:   in_err = !chan_ok || (in_voice != NOISE_VOICE) ||
                            (in_amount > RATE_MAX);
      ACT_RESTART: in_err = !chan_ok || (in_voice != NOISE_VOICE);
      ACT_MUTE:    in_err = 1'b0;
      ACT_PERIOD:  in_err = 1'b0;
      default:     in_err = 1'b1;
    endcase
  end

  // latched command
  logic [2:0]  act_r;
  logic [1:0]  voice_r;
  logic [1:0]  chip_r;
  logic [15:0] amt_r;
  logic        err_r;
  logic [3:0]  idx_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r   <= in_action;
      voice_r <= in_voice;
      chip_r  <= in_chip;
      amt_r   <= in_amount;
      err_r   <= in_err;
    end
  end

  // noise-control shadow, one byte per chip
  logic [7:0] noise_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        noise_r[i] <= BYTE_NOISE;
      end
    end else if (accept && (in_action == ACT_NOISE) && !in_err) begin
      noise_r[in_chip] <= BYTE_NOISE | (in_white_noise ? BYTE_WHITE : 8'd0) |
                          {6'd0, in_amount[1:0]};
    end
  end

  // ---------------------------------------------------------------------
  // period-for-hz: restoring divider, one quotient bit per cycle
  // num_r shifts the dividend out at the top and the quotient in below
  // ---------------------------------------------------------------------
  logic [NUM_W-1:0] num_r;
  logic [15:0]      rem_r;
  logic [4:0]       cnt_r;
  logic [16:0]      trial;
  logic [16:0]      diff;
  logic             q_bit;
  logic [15:0]      rem_nxt;

  assign trial   = {rem_r, num_r[NUM_W-1]};
  assign diff    = trial - {1'b0, amt_r};
  assign q_bit   = (trial >= {1'b0, amt_r});
  assign rem_nxt = q_bit ? diff[15:0] : trial[15:0];

  always_ff @(posedge clk) begin
    if (accept) begin
      // rounding: add half the divisor before dividing
      num_r <= NUM_W'(ratio_r) + NUM_W'(in_amount[15:1]);
      rem_r <= 16'd0;
      cnt_r <= 5'd0;
    end else if (state_r == ST_DIV) begin
      num_r <= {num_r[NUM_W-2:0], q_bit};
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + 5'd1;
    end
  end

  // ---------------------------------------------------------------------
  // result generator for the current emit index
  // ---------------------------------------------------------------------
  logic [1:0]  res_chip;
  logic [7:0]  res_byte;
  logic        res_wr;
  logic        res_st;
  logic [9:0]  res_per;
  logic        res_last;
  logic [3:0]  att;

  assign att = (amt_r > 16'(ATT_MAX)) ? ATT_MAX : amt_r[3:0];

  always_comb begin
    res_chip = chip_r;
    res_byte = 8'd0;
    res_wr   = 1'b1;
    res_st   = 1'b0;
    res_per  = 10'd0;
    res_last = 1'b1;
    if (err_r) begin
      // rejected command: single status-only transaction
      res_chip = 2'd0;
      res_wr   = 1'b0;
      res_st   = 1'b1;
    end else begin
      case (act_r)
        ACT_TONE: begin
          if (idx_r[0] == 1'b0) begin
            res_byte = BYTE_TONE | {1'b0, voice_r, 1'b0, amt_r[3:0]};
            res_last = 1'b0;
          end else begin
            res_byte = {2'b00, amt_r[9:4]};
          end
        end
        ACT_VOLUME: begin
          res_byte = BYTE_VOLUME | {1'b0, voice_r, 1'b0, att};
        end
        ACT_NOISE, ACT_RESTART: begin
          res_byte = noise_r[chip_r];
        end
        ACT_MUTE: begin
          res_chip = idx_r[3:2];
          res_byte = BYTE_MUTE | {1'b0, idx_r[1:0], 5'd0};
          res_last = (idx_r == MUTE_LAST);
        end
        ACT_PERIOD: begin
          res_chip = 2'd0;
          res_wr   = 1'b0;
          // zero divisor, zero quotient or too large a period all read as 0
          if ((amt_r != 16'd0) && (num_r != '0) && (num_r <= QUOT_MAX)) begin
            res_per = num_r[9:0];
          end
        end
        default: begin
          res_chip = 2'd0;
          res_wr   = 1'b0;
          res_st   = 1'b1;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // controller and output register
  // ---------------------------------------------------------------------
  logic        out_free;
  logic        load;
  logic        out_valid_r;
  logic [1:0]  chip_port_r;
  logic [7:0]  byte_r;
  logic        write_valid_r;
  logic        status_r;
  logic [9:0]  period_r;
  logic        last_r;

  assign out_free = !out_valid_r || out_ready;
  assign load     = (state_r == ST_EMIT) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= 4'd0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          idx_r <= 4'd0;
          if (accept) begin
            state_r <= (in_action == ACT_PERIOD) ? ST_DIV : ST_EMIT;
          end
        end
        ST_DIV: begin
          if (cnt_r == DIV_LAST) begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (load) begin
            idx_r <= idx_r + 4'd1;
            if (res_last) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      chip_port_r   <= res_chip;
      byte_r        <= res_byte;
      write_valid_r <= res_wr;
      status_r      <= res_st;
      period_r      <= res_per;
      last_r        <= res_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_chip_port    = chip_port_r;
  assign out_out_byte     = byte_r;
  assign out_write_valid  = write_valid_r;
  assign out_status       = status_r;
  assign out_period_value = period_r;
  assign out_last         = last_r;

`ifndef SYNTHESIS
  // an accepted command always leaves the idle state
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != ST_IDLE))
    else $error("controller stayed idle after accepting a transaction");

  // divider never runs past its last step
  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (cnt_r <= DIV_LAST))
    else $error("divider step count overran");

  // a chip write never carries an error status
  a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_write_valid && out_status))
    else $error("write transaction flagged with error status");

  // a period value only appears on a status-only result
  a_period_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_period_value != 10'd0)) |-> !out_write_valid)
    else $error("period value on a write transaction");

  // a new result is loaded only when the output register is free
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_out_byte))
    else $error("output register overwritten while stalled");
`endif

endmodule

// ===== verif/psg_write_checker.sv =====
// psg_write_checker: predicts the chip byte stream of psg_command_encoder from
// command and apb transactions and compares every result; uses psgce_pkg
module psg_write_checker #(
  parameter int unsigned CHANNELS   = 16,
  parameter logic [2:0]  RATIO_ADDR = 3'd0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  in_action,
  input  logic [7:0]  in_channel,
  input  logic [15:0] in_amount,
  input  logic        in_white_noise,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_chip_port,
  input  logic [7:0]  out_out_byte,
  input  logic        out_write_valid,
  input  logic        out_status,
  input  logic [9:0]  out_period_value,
  input  logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int unsigned mismatches,
  output int unsigned outstanding,
  output int unsigned results_checked
);

  import psgce_pkg::*;

  typedef struct packed {
    logic [1:0] chip_port;
    logic [7:0] cmd_byte;
    logic       write_valid;
    logic       status;
    logic [9:0] period;
    logic       last;
  } chip_write_t;

  chip_write_t byte_queue[$];
  logic [17:0] clock_ratio;
  logic [7:0]  noise_ctl[4];

  function automatic chip_write_t chip_write(logic [1:0] chip, logic [7:0] cmd, logic last);
    chip_write = '{chip_port: chip, cmd_byte: cmd, write_valid: 1'b1, status: 1'b0,
                   period: 10'd0, last: last};
  endfunction

  function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch at result %0d: %s expected %0h got %0h",
               results_checked, what, want, got);
  endfunction

  // expected results of one command, updates the noise control byte
  function automatic void encode_command(logic [2:0] action, logic [7:0] channel,
                                         logic [15:0] amount, logic white);
    logic [1:0]  voice;
    logic [1:0]  chip;
    logic        chan_ok;
    logic [3:0]  att;
    logic [3:0]  idx;
    logic [31:0] num;
    logic [31:0] quot;
    chip_write_t reject;
    voice   = channel[1:0];
    chip    = channel[3:2];
    chan_ok = channel < 8'(CHANNELS);
    reject  = '{chip_port: 2'd0, cmd_byte: 8'd0, write_valid: 1'b0, status: 1'b1,
                period: 10'd0, last: 1'b1};
    case (action)
      ACT_TONE: begin
        if (!chan_ok || voice == NOISE_VOICE || amount == 16'd0 || amount > TONE_MAX) begin
          byte_queue.push_back(reject);
        end else begin
          byte_queue.push_back(chip_write(chip,
            BYTE_TONE | {1'b0, voice, 5'd0} | {4'd0, amount[3:0]}, 1'b0));
          byte_queue.push_back(chip_write(chip, {2'd0, amount[9:4]}, 1'b1));
        end
      end
      ACT_VOLUME: begin
        if (!chan_ok) begin
          byte_queue.push_back(reject);
        end else begin
          att = (amount > {12'd0, ATT_MAX}) ? ATT_MAX : amount[3:0];
          byte_queue.push_back(chip_write(chip,
            BYTE_VOLUME | {1'b0, voice, 5'd0} | {4'd0, att}, 1'b1));
        end
      end
      ACT_NOISE: begin
        if (!chan_ok || voice != NOISE_VOICE || amount > RATE_MAX) begin
          byte_queue.push_back(reject);
        end else begin
          noise_ctl[chip] = BYTE_NOISE | (white ? BYTE_WHITE : 8'd0) | {6'd0, amount[1:0]};
          byte_queue.push_back(chip_write(chip, noise_ctl[chip], 1'b1));
        end
      end
      ACT_RESTART: begin
        if (!chan_ok || voice != NOISE_VOICE)
          byte_queue.push_back(reject);
        else
          byte_queue.push_back(chip_write(chip, noise_ctl[chip], 1'b1));
      end
      ACT_MUTE: begin
        for (int k = 0; k < 16; k++) begin
          idx = k[3:0];
          byte_queue.push_back(chip_write(idx[3:2], BYTE_MUTE | {1'b0, idx[1:0], 5'd0},
                                          idx == MUTE_LAST));
        end
      end
      ACT_PERIOD: begin
        quot = 32'd0;
        if (amount != 16'd0) begin
          num  = {14'd0, clock_ratio} + {17'd0, amount[15:1]};
          quot = num / {16'd0, amount};
          if (quot > {13'd0, QUOT_MAX})
            quot = 32'd0;
        end
        byte_queue.push_back('{chip_port: 2'd0, cmd_byte: 8'd0, write_valid: 1'b0,
                               status: 1'b0, period: quot[9:0], last: 1'b1});
      end
      default: byte_queue.push_back(reject);
    endcase
  endfunction

  always @(posedge clk) begin
    chip_write_t want;
    if (!rst_n) begin
      clock_ratio = RATIO_RESET;
      for (int i = 0; i < 4; i++)
        noise_ctl[i] = BYTE_NOISE;
      byte_queue.delete();
    end else begin
      // results first: a result never belongs to a command taken at the same edge
      if (out_valid && out_ready) begin
        if (byte_queue.size() == 0) begin
          note_mismatch("result with no command waiting, byte", 32'd0, {24'd0, out_out_byte});
        end else begin
          want = byte_queue.pop_front();
          if (out_chip_port !== want.chip_port)
            note_mismatch("chip_port", 32'(want.chip_port), 32'(out_chip_port));
          if (out_out_byte !== want.cmd_byte)
            note_mismatch("out_byte", 32'(want.cmd_byte), 32'(out_out_byte));
          if (out_write_valid !== want.write_valid)
            note_mismatch("write_valid", 32'(want.write_valid), 32'(out_write_valid));
          if (out_status !== want.status)
            note_mismatch("status", 32'(want.status), 32'(out_status));
          if (out_period_value !== want.period)
            note_mismatch("period_value", 32'(want.period), 32'(out_period_value));
          if (out_last !== want.last)
            note_mismatch("last", 32'(want.last), 32'(out_last));
        end
        results_checked++;
      end
      if (in_valid && in_ready)
        encode_command(in_action, in_channel, in_amount, in_white_noise);
      if (psel && penable && pready && paddr == RATIO_ADDR) begin
        if (pwrite)
          clock_ratio = pwdata[17:0];
        else if (prdata !== {14'd0, clock_ratio})
          note_mismatch("clock_ratio read", {14'd0, clock_ratio}, prdata);
      end
    end
    outstanding = byte_queue.size();
  end

endmodule

// ===== verif/psg_command_encoder_test.sv =====
// psg_command_encoder_test: drives commands and clock_ratio writes into the
// encoder with random gaps and stalls; depends on psgce_pkg and psg_write_checker
module psg_command_encoder_test;
  import psgce_pkg::*;

  localparam int unsigned N_CHANNELS   = 16;
  localparam logic [2:0]  ADDR_RATIO   = 3'd0;
  // action codes the block does not know
  localparam logic [2:0]  ACT_SPARE_LO = 3'd6;
  localparam logic [2:0]  ACT_SPARE_HI = 3'd7;
  localparam int unsigned IDLE_LIMIT   = 5000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned HOLD_AT      = 200;
  localparam int unsigned PHASE_ITEMS  = 88;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_action = 3'd0;
  logic [7:0]  in_channel = 8'd0;
  logic [15:0] in_amount = 16'd0;
  logic        in_white_noise = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_chip_port;
  logic [7:0]  out_out_byte;
  logic        out_write_valid;
  logic        out_status;
  logic [9:0]  out_period_value;
  logic        out_last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned results_checked;
  int unsigned commands_sent = 0;
  int unsigned ratio_settings = 1;
  int unsigned idle_cycles = 0;
  // when set, neither side inserts random gaps; the one long result hold-off still applies
  bit          calm = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  psg_command_encoder #(.CHANNELS(N_CHANNELS)) dut (.*);

  psg_write_checker #(.CHANNELS(N_CHANNELS), .RATIO_ADDR(ADDR_RATIO)) write_check (.*);

  // watchdog: too long without any transaction on any port ends the run
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // result side: random stall per result, one long hold-off to back up the block
  initial begin
    int unsigned taken;
    int unsigned wait_n;
    taken = 0;
    wait (rst_n);
    forever begin
      if (taken == HOLD_AT)
        wait_n = HOLD_CYCLES;
      else if (calm)
        wait_n = 0;
      else
        wait_n = $urandom_range(0, 10);
      if (wait_n != 0) begin
        out_ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  // one command transaction, with a random gap in front of it
  task automatic send_command(input logic [2:0] action, input logic [7:0] channel,
                              input logic [15:0] amount, input logic white);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= action;
    in_channel     <= channel;
    in_amount      <= amount;
    in_white_noise <= white;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    commands_sent++;
  endtask

  // wait until every expected result is in and the divider has surely finished
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one apb transaction on the clock_ratio register: setup, then access
  task automatic apb_access(input logic write, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= ADDR_RATIO;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // write, then read back so the checker sees the register value
  task automatic set_clock_ratio(input logic [17:0] ratio);
    apb_access(1'b1, {14'd0, ratio});
    apb_access(1'b0, 32'd0);
    ratio_settings++;
  endtask

  // mostly well-formed commands, some with bad channels, arguments or actions
  task automatic send_random(input int unsigned count);
    logic [2:0]  action;
    logic [7:0]  channel;
    logic [15:0] amount;
    logic [1:0]  chip;
    int unsigned pick;
    repeat (count) begin
      if ($urandom_range(0, 29) == 0)
        calm = ($urandom_range(0, 2) == 0);
      pick   = $urandom_range(0, 99);
      amount = 16'($urandom_range(0, 65535));
      chip   = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 9) == 0)
        channel = 8'($urandom_range(0, 255));
      else
        channel = 8'($urandom_range(0, N_CHANNELS - 1));
      if (pick < 25) begin
        action = ACT_TONE;
        if ($urandom_range(0, 6) != 0)
          amount = 16'($urandom_range(1, 1023));
      end else if (pick < 45) begin
        action = ACT_VOLUME;
        if ($urandom_range(0, 2) != 0)
          amount = 16'($urandom_range(0, 20));
      end else if (pick < 60) begin
        action = ACT_NOISE;
        if ($urandom_range(0, 4) != 0)
          amount = 16'($urandom_range(0, 3));
        if ($urandom_range(0, 4) != 0)
          channel = {4'd0, chip, NOISE_VOICE};
      end else if (pick < 73) begin
        action = ACT_RESTART;
        if ($urandom_range(0, 4) != 0)
          channel = {4'd0, chip, NOISE_VOICE};
      end else if (pick < 78) begin
        action = ACT_MUTE;
      end else if (pick < 93) begin
        action = ACT_PERIOD;
        case ($urandom_range(0, 3))
          0: amount = 16'($urandom_range(0, 2));
          1: amount = 16'($urandom_range(1, 16));
          2: amount = 16'($urandom_range(100, 5000));
          default: ;
        endcase
      end else begin
        action = $urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO;
      end
      send_command(action, channel, amount, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    logic [17:0] ratios[5];
    ratios[0] = 18'd1;
    ratios[1] = 18'h3ffff;
    ratios[2] = 18'($urandom_range(1, 262143));
    ratios[3] = 18'($urandom_range(1000, 5000));
    ratios[4] = RATIO_RESET;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed commands at the reset clock_ratio
    send_command(ACT_TONE, 8'd0, 16'd1, 1'b0);
    send_command(ACT_TONE, 8'd1, 16'd1023, 1'b1);
    send_command(ACT_TONE, 8'd2, 16'd0, 1'b0);          // period zero rejected
    send_command(ACT_TONE, 8'd5, 16'd1024, 1'b0);       // period too large
    send_command(ACT_TONE, 8'd3, 16'd100, 1'b0);        // tone on the noise voice
    send_command(ACT_TONE, 8'd16, 16'd100, 1'b0);       // channel out of range
    send_command(ACT_VOLUME, 8'd255, 16'd5, 1'b1);
    send_command(ACT_VOLUME, 8'd0, 16'd0, 1'b0);
    send_command(ACT_VOLUME, 8'd6, 16'd15, 1'b0);
    send_command(ACT_VOLUME, 8'd9, 16'hffff, 1'b1);     // attenuation saturates
    send_command(ACT_RESTART, 8'd3, 16'd0, 1'b0);       // shadow still at reset
    send_command(ACT_NOISE, 8'd3, 16'd0, 1'b1);
    send_command(ACT_NOISE, 8'd7, 16'd3, 1'b0);
    send_command(ACT_NOISE, 8'd11, 16'd4, 1'b1);        // rate too large
    send_command(ACT_NOISE, 8'd2, 16'd1, 1'b1);         // not the noise voice
    send_command(ACT_RESTART, 8'd3, 16'hffff, 1'b1);
    send_command(ACT_RESTART, 8'd15, 16'd0, 1'b0);
    send_command(ACT_RESTART, 8'd14, 16'd0, 1'b0);
    send_command(ACT_RESTART, 8'd19, 16'd0, 1'b0);
    send_command(ACT_MUTE, 8'd255, 16'hffff, 1'b1);
    send_command(ACT_PERIOD, 8'd0, 16'd0, 1'b0);        // divide by zero gives 0
    send_command(ACT_PERIOD, 8'd0, 16'd1, 1'b0);        // quotient over 1023 gives 0
    send_command(ACT_PERIOD, 8'd0, 16'd440, 1'b0);
    send_command(ACT_PERIOD, 8'd0, 16'hffff, 1'b0);
    send_command(ACT_SPARE_LO, 8'd0, 16'd0, 1'b0);
    send_command(ACT_SPARE_HI, 8'hff, 16'hffff, 1'b1);

    // random phases, one clock_ratio setting each, written while idle
    foreach (ratios[p]) begin
      drain();
      set_clock_ratio(ratios[p]);
      send_command(ACT_PERIOD, 8'd0, 16'd1, 1'b0);
      send_command(ACT_PERIOD, 8'd0, 16'hffff, 1'b0);
      send_random(PHASE_ITEMS);
    end
    drain();

    $display("%0d commands over %0d clock_ratio settings, %0d results checked",
             commands_sent, ratio_settings, results_checked);
    if (mismatches == 0 && outstanding == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
